// File: hdl/lsr_pkg.sv
// Shared types and constants for the line segment rasterizer.
package lsr_pkg;

   localparam int COORD_BITS   = 10;
   localparam int SIZE_BITS    = COORD_BITS + 1;
   localparam int ROW_BITS     = COORD_BITS + 2;
   localparam int COLOR_BITS   = 16;
   localparam int DIV_CNT_BITS = $clog2(SIZE_BITS + 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [COLOR_BITS-1:0] color;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [SIZE_BITS-1:0]  rect_w;
      logic [SIZE_BITS-1:0]  rect_h;
      logic [COLOR_BITS-1:0] fill_color;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: hdl/line_segment_rasterizer.sv
// Line segment rasterizer: turns a line into a run of filled rectangles.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   lsr_pkg::req_type (start or next)
//   rsp      out        rsp_valid/rsp_stall   lsr_pkg::rsp_type (one rectangle)
//
// A start transaction gives no result and leaves the sequencer idle.
// A next transaction passes through setup, the bit-serial divide (one quotient bit
// per cycle) and the final step before the next request is taken.
// A next transaction with no line loaded is dropped without leaving the idle state.
// Reset is synchronous and clears the line; there is no clearing pass.
// A finished rectangle waits in the output register; a stalled result holds the
// sequencer in its final step until the register frees.
module line_segment_rasterizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lsr_pkg::rsp_type rsp_data
);

   localparam int CW = lsr_pkg::COORD_BITS;
   localparam int SW = lsr_pkg::SIZE_BITS;
   localparam int YW = lsr_pkg::ROW_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0]                 cur_x_ff, cur_x_in;
   logic signed [YW-1:0]          cur_y_ff, cur_y_in;
   logic [CW-1:0]                 end_x_ff, end_x_in;
   logic [CW-1:0]                 end_y_ff, end_y_in;
   logic [lsr_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic                          active_ff, active_in;
   logic                          steep_ff, steep_in;
   logic                          falling_ff, falling_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lsr_pkg::rsp_type              rsp_ff, rsp_in;

   logic                    req_take;
   logic                    out_free;
   logic [SW-1:0]           run;
   logic signed [YW-1:0]    rise;
   logic signed [YW-1:0]    m_full;
   logic [SW-1:0]           m;
   logic                    div_start;
   logic [SW-1:0]           div_num;
   logic [SW-1:0]           div_den;
   logic [SW-1:0]           div_quot;
   lsr_pkg::div_status_type div_stat;
   logic [SW-1:0]           w_raw;
   logic [SW-1:0]           h_raw;
   logic signed [YW-1:0]    h_ext;
   logic signed [YW-1:0]    top_raw;
   logic                    clip;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Slope setup: run and rise of the remaining segment.
   assign run    = SW'({1'b0, end_x_ff}) - cur_x_ff + SW'(1);
   assign rise   = $signed(YW'({2'b00, end_y_ff})) - cur_y_ff;
   assign m_full = rise[YW-1] ? (YW'(1) - rise) : (rise + YW'(1));
   assign m      = m_full[SW-1:0];

   assign div_start = (state_ff == ST_SETUP);
   assign div_num   = (m > run) ? m : run;
   assign div_den   = (m > run) ? run : m;

   lsr_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_stat),
      .quot   (div_quot)
   );

   // Rectangle placement from the quotient.
   assign w_raw   = steep_ff ? SW'(1) : div_quot;
   assign h_raw   = steep_ff ? div_quot : SW'(1);
   assign h_ext   = $signed({1'b0, h_raw});
   assign top_raw = falling_ff ? (cur_y_ff - h_ext) : cur_y_ff;
   assign clip    = top_raw[YW-1];

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      color_in     = color_ff;
      active_in    = active_ff;
      steep_in     = steep_ff;
      falling_in   = falling_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.op == lsr_pkg::OP_START) begin
                  // Order the endpoints so that columns grow toward the end point.
                  if (req_data.x_start > req_data.x_end) begin
                     cur_x_in = {1'b0, req_data.x_end};
                     cur_y_in = $signed({2'b00, req_data.y_end});
                     end_x_in = req_data.x_start;
                     end_y_in = req_data.y_start;
                  end else begin
                     cur_x_in = {1'b0, req_data.x_start};
                     cur_y_in = $signed({2'b00, req_data.y_start});
                     end_x_in = req_data.x_end;
                     end_y_in = req_data.y_end;
                  end
                  color_in  = req_data.color;
                  active_in = 1'b1;
               end else if (active_ff) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            steep_in   = (m > run);
            falling_in = rise[YW-1];
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cur_x_in          = cur_x_ff + w_raw;
               cur_y_in          = falling_ff ? top_raw : (cur_y_ff + h_ext);
               rsp_in.rect_x     = cur_x_ff[CW-1:0];
               rsp_in.rect_y     = clip ? '0 : top_raw[CW-1:0];
               rsp_in.rect_w     = w_raw;
               rsp_in.rect_h     = clip ? (h_raw + top_raw[SW-1:0]) : h_raw;
               rsp_in.fill_color = color_ff;
               rsp_in.last       = (cur_x_in > {1'b0, end_x_ff});
               active_in         = !rsp_in.last;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         color_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         color_ff     <= color_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff   <= steep_in;
      falling_ff <= falling_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // A new result is loaded only by the final step of the sequencer.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result appeared outside the final step");

   // A rectangle marked last leaves no line loaded behind it.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_ff.last) |-> !active_ff)
      else $error("line still active after its last rectangle");

   // The divider reports completion only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   // Every rectangle is a single column or at most a single row.
   a_rect_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.rect_w == SW'(1) || rsp_ff.rect_h <= SW'(1)))
      else $error("rectangle is neither one column wide nor one row tall");
`endif

endmodule

// File: hdl/lsr_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module lsr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lsr_pkg::SIZE_BITS-1:0] num,
   input  logic [lsr_pkg::SIZE_BITS-1:0] den,
   output lsr_pkg::div_status_type       status,
   output logic [lsr_pkg::SIZE_BITS-1:0] quot
);

   logic [lsr_pkg::SIZE_BITS-1:0]    rem_ff;
   logic [lsr_pkg::SIZE_BITS-1:0]    quot_ff;
   logic [lsr_pkg::SIZE_BITS-1:0]    den_ff;
   logic [lsr_pkg::DIV_CNT_BITS-1:0] count_ff;
   logic                             done_ff;

   logic [lsr_pkg::SIZE_BITS:0] shifted;
   logic [lsr_pkg::SIZE_BITS:0] diff;
   logic                        fits;

   // The next dividend bit enters from the top of the quotient register as it shifts out.
   assign shifted = {rem_ff, quot_ff[lsr_pkg::SIZE_BITS-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            count_ff <= lsr_pkg::DIV_CNT_BITS'(lsr_pkg::SIZE_BITS);
         end else if (count_ff != '0) begin
            count_ff <= count_ff - lsr_pkg::DIV_CNT_BITS'(1);
            done_ff  <= (count_ff == lsr_pkg::DIV_CNT_BITS'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= num;
         den_ff  <= den;
      end else if (count_ff != '0) begin
         rem_ff  <= fits ? diff[lsr_pkg::SIZE_BITS-1:0] : shifted[lsr_pkg::SIZE_BITS-1:0];
         quot_ff <= {quot_ff[lsr_pkg::SIZE_BITS-2:0], fits};
      end
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign quot        = quot_ff;

endmodule
